/* src/wmd_pkg.sv */
// shared types and constants for the window maximum distance line pass
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wmd_pkg;

    // line storage geometry
    localparam int LINE_MAX   = 256;
    localparam int ADDR_W     = $clog2(LINE_MAX);
    localparam int PTR_W      = ADDR_W + 1;
    localparam int SCORE_W    = 16;
    localparam int WIN_W      = 16;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [SCORE_W-1:0] score_t;
    typedef logic [WIN_W-1:0]   win_t;

    // one cell of the line as it arrives
    typedef struct packed {
        score_t prev_score;
        logic   prev_reachable;
        logic   blocked;
        logic   last_in_line;
    } cell_in_t;

    // one result cell
    typedef struct packed {
        score_t new_score;
        logic   new_reachable;
        logic   line_end;
    } cell_out_t;

    // one deque entry
    typedef struct packed {
        score_t score;
        addr_t  position;
    } entry_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_TAIL,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* src/window_max_distance_line_pass_core.sv */
// window maximum distance line pass: monotonic deque held in a two-read-port memory
// depends on wmd_pkg
// one cell at a time: S_IDLE accepts, S_HEAD drops entries that have left the window,
// S_TAIL drops dominated entries and pushes a reachable cell, S_DONE loads the result
// once the output is free; blocked cells skip S_HEAD and S_TAIL, unreachable ones S_TAIL
// reset: asynchronous active low; empties the deque, position zero, window_len 1
`timescale 1ns / 1ps
`default_nettype none

module window_max_distance_line_pass_core
    import wmd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire win_t      cfg_wr_data,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire cell_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output cell_out_t      out_data
);

    // deque storage and its read ports
    entry_t    mem [LINE_MAX];
    entry_t    rd_a_reg;
    entry_t    rd_b_reg;
    logic      re_a;
    logic      re_b;
    addr_t     ra;
    addr_t     rb;
    logic      we;
    addr_t     wa;
    entry_t    wd;

    // control state
    state_t    state_reg, state_next;
    ptr_t      head_reg, head_next;
    ptr_t      tail_reg, tail_next;
    addr_t     pos_reg, pos_next;
    win_t      window_reg;
    cell_in_t  cur_reg, cur_next;
    logic      out_valid_reg, out_valid_next;
    cell_out_t out_data_reg, out_data_next;

    // datapath
    addr_t     dist_a;
    addr_t     dist_b;
    logic      too_far;
    logic [SCORE_W:0] sum_b;
    logic      dominated;
    entry_t    front;
    addr_t     dist_f;
    logic [SCORE_W:0] sum_f;
    logic      front_valid;
    logic      restart;

    // memory write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    // memory read ports, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rd_a_reg <= mem[ra];
        end
        if (re_b)
        begin
            rd_b_reg <= mem[rb];
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= win_t'(1);
        end
        else if (cfg_wr_en)
        begin
            window_reg <= cfg_wr_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    // distance and dominance checks on the read entries
    always_comb
    begin
        dist_a    = pos_reg - rd_a_reg.position;
        dist_b    = pos_reg - rd_b_reg.position;
        too_far   = {{(WIN_W-ADDR_W){1'b0}}, dist_a} > window_reg;
        sum_b     = {1'b0, rd_b_reg.score} + {{(SCORE_W+1-ADDR_W){1'b0}}, dist_b};
        dominated = sum_b <= {1'b0, cur_reg.prev_score};
    end

    // front of the deque, forwarding the pushed cell when it is the only entry
    always_comb
    begin
        if (cur_reg.prev_reachable && (head_reg == tail_reg - ptr_t'(1)))
        begin
            front.score    = cur_reg.prev_score;
            front.position = pos_reg;
        end
        else
        begin
            front = rd_a_reg;
        end
        dist_f      = pos_reg - front.position;
        sum_f       = {1'b0, front.score} + {{(SCORE_W+1-ADDR_W){1'b0}}, dist_f};
        front_valid = head_reg < tail_reg;
        restart     = cur_reg.last_in_line || (pos_reg == addr_t'(LINE_MAX - 1));
    end

    // sequencer: next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        re_a           = 1'b0;
        re_b           = 1'b0;
        ra             = head_reg[ADDR_W-1:0];
        rb             = tail_reg[ADDR_W-1:0] - addr_t'(1);
        we             = 1'b0;
        wa             = tail_reg[ADDR_W-1:0];
        wd.score       = cur_reg.prev_score;
        wd.position    = pos_reg;
        in_ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cur_next   = in_data;
                    re_a       = 1'b1;
                    state_next = in_data.blocked ? S_DONE : S_HEAD;
                end
            end

            // drop entries that have fallen out of the window
            S_HEAD:
            begin
                if (front_valid && too_far)
                begin
                    head_next = head_reg + ptr_t'(1);
                    re_a      = 1'b1;
                    ra        = head_reg[ADDR_W-1:0] + addr_t'(1);
                end
                else if (cur_reg.prev_reachable)
                begin
                    re_b       = 1'b1;
                    state_next = S_TAIL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // drop dominated entries at the back, then push this cell if the store has room
            S_TAIL:
            begin
                if ((tail_reg > head_reg) && dominated)
                begin
                    tail_next = tail_reg - ptr_t'(1);
                    re_b      = 1'b1;
                    rb        = tail_reg[ADDR_W-1:0] - addr_t'(2);
                end
                else
                begin
                    if (tail_reg < ptr_t'(LINE_MAX))
                    begin
                        we        = 1'b1;
                        tail_next = tail_reg + ptr_t'(1);
                    end
                    state_next = S_DONE;
                end
            end

            // load the result once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.line_end  = cur_reg.last_in_line;
                    if (!cur_reg.blocked && front_valid)
                    begin
                        out_data_next.new_reachable = 1'b1;
                        out_data_next.new_score     = sum_f[SCORE_W] ? '1
                                                      : sum_f[SCORE_W-1:0];
                    end
                    else
                    begin
                        out_data_next.new_reachable = 1'b0;
                        out_data_next.new_score     = '0;
                    end
                    if (cur_reg.blocked || restart)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    pos_next   = restart ? '0 : pos_reg + addr_t'(1);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // deque bounds never cross
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("deque head passed tail");

    // between cells the deque holds no more entries than cells seen in the line
    a_tail_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (tail_reg <= {1'b0, pos_reg}))
        else $error("deque longer than the line so far");

    // a blocked cell always gives an unreachable result and empties the deque
    a_blocked_unreach: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || out_ready) && cur_reg.blocked)
        |=> (out_valid && !out_data.new_reachable && head_reg == '0 && tail_reg == '0))
        else $error("blocked cell gave a reachable result");

    // no memory write outside the push step
    a_write_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == S_TAIL))
        else $error("deque write outside the push step");

endmodule

`default_nettype wire

/* sim/window_max_distance_line_pass_core_test.sv */
// testbench for window_max_distance_line_pass_core: directed and random lines checked
// against a behavioural deque predictor, with random idling on both sides
// depends on wmd_pkg and window_max_distance_line_pass_core
`timescale 1ns / 1ps
`default_nettype none

module window_max_distance_line_pass_core_test;
    import wmd_pkg::*;

    localparam int SCORE_LIMIT = (1 << SCORE_W) - 1;
    localparam int EXP_DEPTH   = 64;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_wr_en = 1'b0;
    win_t      cfg_wr_data = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    cell_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    cell_out_t out_data;

    // predictor state: deque of (score, position) plus line position and window
    score_t    dq_score [LINE_MAX];
    addr_t     dq_pos [LINE_MAX];
    int        dq_head = 0;
    int        dq_tail = 0;
    int        line_pos = 0;
    win_t      window_len = 1;

    // expected results in order, as a ring with running write and read counts
    cell_out_t expected_cells [EXP_DEPTH];
    int        exp_wr = 0;
    int        exp_rd = 0;
    int        errors = 0;
    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;

    window_max_distance_line_pass_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // new score of one cell: window maximum of earlier score plus distance
    function automatic cell_out_t predict_cell(cell_in_t c);
        cell_out_t r;
        int        best;
        r = '0;
        if (c.blocked)
        begin
            dq_head = 0;
            dq_tail = 0;
        end
        else
        begin
            // entries too far back leave at the head
            while (dq_head < dq_tail && line_pos - int'(dq_pos[dq_head]) > int'(window_len))
                dq_head++;
            if (c.prev_reachable)
            begin
                // dominated entries leave at the tail; compare on the exact sum
                while (dq_tail > dq_head && int'(dq_score[dq_tail-1]) + line_pos
                       - int'(dq_pos[dq_tail-1]) <= int'(c.prev_score))
                    dq_tail--;
                if (dq_tail < LINE_MAX)
                begin
                    dq_score[dq_tail] = c.prev_score;
                    dq_pos[dq_tail]   = addr_t'(line_pos);
                    dq_tail++;
                end
            end
            if (dq_head < dq_tail)
            begin
                best = int'(dq_score[dq_head]) + line_pos - int'(dq_pos[dq_head]);
                r.new_score     = (best > SCORE_LIMIT) ? score_t'(SCORE_LIMIT) : score_t'(best);
                r.new_reachable = 1'b1;
            end
        end
        r.line_end = c.last_in_line;
        // end of line, or a line that fills the store, restarts the pass
        if (c.last_in_line || line_pos + 1 >= LINE_MAX)
        begin
            line_pos = 0;
            dq_head  = 0;
            dq_tail  = 0;
        end
        else
            line_pos++;
        return r;
    endfunction

    function automatic cell_in_t make_cell(score_t s, bit reach, bit blk, bit last);
        cell_in_t c;
        c.prev_score     = s;
        c.prev_reachable = reach;
        c.blocked        = blk;
        c.last_in_line   = last;
        return c;
    endfunction

    // random cell, scores mostly close together so the deque has real work
    function automatic cell_in_t random_cell(bit last);
        score_t s;
        int     pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            s = score_t'($urandom_range(0, 40));
        else if (pick < 7)
            s = score_t'($urandom);
        else if (pick < 9)
            s = score_t'($urandom_range(SCORE_LIMIT - 135, SCORE_LIMIT));
        else
            s = $urandom_range(0, 1) ? score_t'(SCORE_LIMIT) : '0;
        return make_cell(s, $urandom_range(0, 99) < 75, $urandom_range(0, 99) < 8, last);
    endfunction

    // one input transaction; valid stays high when the next one follows at once
    task automatic send_cell(cell_in_t c);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do @(posedge clk); while (in_ready !== 1'b1);
        expected_cells[exp_wr % EXP_DEPTH] = predict_cell(c);
        exp_wr++;
    endtask

    // lower valid and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
    endtask

    // register write only while the block is idle
    task automatic write_window_len(win_t v);
        drain_results();
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        window_len  = v;
    endtask

    // reset window of one: neighbour carries, no score in window at line start
    task automatic test_reset_window();
        send_cell(make_cell(16'd10, 1'b0, 1'b0, 1'b0));
        send_cell(make_cell(16'd10, 1'b1, 1'b0, 1'b0));
        send_cell(make_cell(16'd5, 1'b1, 1'b0, 1'b0));
        send_cell(make_cell(16'd0, 1'b0, 1'b0, 1'b0));
        send_cell(make_cell(16'd0, 1'b0, 1'b0, 1'b1));
    endtask

    // blocked cell empties the deque
    task automatic test_blocked();
        write_window_len(16'd3);
        send_cell(make_cell(16'd100, 1'b1, 1'b0, 1'b0));
        send_cell(make_cell(16'd200, 1'b1, 1'b1, 1'b0));
        send_cell(make_cell(16'd0, 1'b0, 1'b0, 1'b0));
        send_cell(make_cell(16'd0, 1'b1, 1'b0, 1'b1));
    endtask

    // saturation of the result with exact comparison underneath
    task automatic test_saturation();
        write_window_len(16'hFFFF);
        send_cell(make_cell(16'hFFFF, 1'b1, 1'b0, 1'b0));
        send_cell(make_cell(16'h0000, 1'b0, 1'b0, 1'b0));
        send_cell(make_cell(16'hFFFE, 1'b1, 1'b0, 1'b0));
        send_cell(make_cell(16'hFFFF, 1'b1, 1'b0, 1'b1));
    endtask

    // window of zero: only the cell itself counts
    task automatic test_window_zero();
        write_window_len(16'd0);
        send_cell(make_cell(16'd7, 1'b1, 1'b0, 1'b0));
        send_cell(make_cell(16'd9, 1'b0, 1'b0, 1'b0));
        send_cell(make_cell(16'd0, 1'b1, 1'b0, 1'b1));
    endtask

    // line longer than the store: deque grows long, then the pass wraps
    task automatic test_line_wrap();
        int i;
        write_window_len(16'd255);
        tx_calm = 1'b1;
        for (i = 0; i < 200; i++)
            send_cell(make_cell(score_t'(60000 - 2 * i), 1'b1, 1'b0, 1'b0));
        tx_calm = 1'b0;
        // a large score sweeps the whole deque from the tail
        send_cell(make_cell(16'd62000, 1'b1, 1'b0, 1'b0));
        for (i = 201; i < 270; i++)
            send_cell(random_cell(1'b0));
        send_cell(make_cell(16'd3, 1'b1, 1'b0, 1'b1));
    endtask

    // random lines under one window setting
    task automatic test_random_lines(win_t w, int count);
        int sent;
        int len;
        int i;
        write_window_len(w);
        sent = 0;
        while (sent < count)
        begin
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
            tx_calm = ($urandom_range(0, 3) == 0);
            for (i = 0; i < len && sent < count; i++)
            begin
                send_cell(random_cell(i == len - 1));
                sent++;
            end
        end
        tx_calm = 1'b0;
    endtask

    // sender pauses mid-run until every result is back
    task automatic test_pause();
        test_random_lines(16'd4, 30);
        drain_results();
        test_random_lines(16'd4, 30);
    endtask

    // result side: random stall per transaction, then compare with the oldest expectation
    initial
    begin
        int        stall;
        cell_out_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = ~rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = expected_cells[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (out_data.new_score !== want.new_score)
                begin
                    $display("%0t: new_score expected %0d actual %0d",
                             $time, want.new_score, out_data.new_score);
                    errors++;
                end
                if (out_data.new_reachable !== want.new_reachable)
                begin
                    $display("%0t: new_reachable expected %0b actual %0b",
                             $time, want.new_reachable, out_data.new_reachable);
                    errors++;
                end
                if (out_data.line_end !== want.line_end)
                begin
                    $display("%0t: line_end expected %0b actual %0b",
                             $time, want.line_end, out_data.line_end);
                    errors++;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_blocked();
        test_saturation();
        test_window_zero();
        test_line_wrap();
        test_random_lines(16'd2, 60);
        test_random_lines(16'd5, 60);
        test_pause();
        test_random_lines(16'd17, 60);
        test_random_lines(16'd255, 60);
        test_random_lines(16'd256, 50);
        test_random_lines(16'hFFFF, 50);
        test_random_lines(win_t'($urandom_range(1, 40)), 50);
        test_random_lines(16'd1, 50);
        test_random_lines(16'd0, 40);
        test_random_lines(win_t'($urandom), 40);

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
src/wmd_pkg.sv
src/window_max_distance_line_pass_core.sv
sim/window_max_distance_line_pass_core_test.sv
